// ===== hw/rtl/clarke_park_current_transform_macros.svh =====
// Assertion macros used by the transform back end.
`ifndef CLARKE_PARK_CURRENT_TRANSFORM_MACROS_SVH
`define CLARKE_PARK_CURRENT_TRANSFORM_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CPT_ASSERT_IMPL(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);
// Next-cycle implication checked on every rising clock edge outside reset.
`define CPT_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`endif

// ===== hw/rtl/cpt_pkg.sv =====
// Package with constants, types and helper functions of the current transform.
`timescale 1ns / 1ps
`default_nettype none
package cpt_pkg;
    localparam int unsigned AngleTableBitsDefault = 10;
    localparam logic [12:0] ThreshReset = 13'd3686;
    localparam logic signed [31:0] Inv3Q30 = 32'sd357913941;
    localparam logic signed [31:0] Inv3Sq3Q30 = 32'sd206641710;
    localparam logic signed [33:0] CordicGain = 34'sd652032874;
    localparam int unsigned CordicSteps = 18;
    localparam int unsigned QueueDepth = 4;

    typedef struct packed {
        logic signed [15:0] phase_a_current;
        logic signed [15:0] phase_b_current;
        logic signed [15:0] phase_c_current;
        logic [12:0]        duty_a;
        logic [12:0]        duty_b;
        logic [12:0]        duty_c;
        logic [2:0]         sector;
        logic [15:0]        electrical_angle;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] i_alpha;
        logic signed [15:0] i_beta;
        logic signed [15:0] i_d;
        logic signed [15:0] i_q;
        logic signed [15:0] dc_current;
    } t_out_item;

    // Classified request handed from the front to the back.
    typedef struct packed {
        logic signed [18:0] a3;
        logic signed [18:0] b3;
        logic [15:0]        angle;
    } t_work;

    function automatic logic signed [33:0] atan_step(input int unsigned i);
        logic signed [33:0] v;
        begin
            case (i)
                0: v = 34'sd536870912;  1: v = 34'sd316933406;
                2: v = 34'sd167458907;  3: v = 34'sd85004756;
                4: v = 34'sd42667331;   5: v = 34'sd21354465;
                6: v = 34'sd10679838;   7: v = 34'sd5340245;
                8: v = 34'sd2670163;    9: v = 34'sd1335087;
                10: v = 34'sd667544;    11: v = 34'sd333772;
                12: v = 34'sd166886;    13: v = 34'sd83443;
                14: v = 34'sd41722;     15: v = 34'sd20861;
                16: v = 34'sd10430;     default: v = 34'sd5215;
            endcase
            atan_step = v;
        end
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [35:0] v);
        begin
            if (v > 36'sd32767) sat16 = 16'sh7fff;
            else if (v < -36'sd32768) sat16 = 16'sh8000;
            else sat16 = v[15:0];
        end
    endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/cpt_stream_if.sv =====
// Valid/ready stream interface used for the external channels of the transform.
`timescale 1ns / 1ps
`default_nettype none
interface cpt_stream_if #(parameter int unsigned W = 8);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/cpt_front.sv =====
// Front end: duty check, phase rebuild or mean removal, registered.
`timescale 1ns / 1ps
`default_nettype none
module cpt_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    cpt_stream_if.sink         in_req,
    cpt_stream_if.sink         cfg_req,
    output cpt_pkg::t_work     o_work,
    output logic               o_valid,
    input  wire logic          i_ready
);
    logic [12:0]      r_thresh;
    cpt_pkg::t_work   r_work, n_work;
    logic             r_valid;
    cpt_pkg::t_in_item it;
    logic signed [18:0] a, b, c, pa, pb;
    logic drop;

    assign it = in_req.data;
    assign cfg_req.ready = 1'b1;
    assign in_req.ready = !r_valid || i_ready;

    always_comb begin
        a = 19'(it.phase_a_current);
        b = 19'(it.phase_b_current);
        c = 19'(it.phase_c_current);
        drop = (it.duty_a > r_thresh) || (it.duty_b > r_thresh) || (it.duty_c > r_thresh);
        pa = a;
        pb = b;
        case (it.sector)
            3'd1, 3'd6: pa = -b - c;
            3'd2, 3'd3: pb = -a - c;
            default: ;
        endcase
        if (drop) begin
            n_work.a3 = 19'(3 * pa);
            n_work.b3 = 19'(3 * pb);
        end else begin
            n_work.a3 = 19'(2 * a - b - c);
            n_work.b3 = 19'(2 * b - a - c);
        end
        n_work.angle = it.electrical_angle;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= cpt_pkg::ThreshReset;
            r_valid <= 1'b0;
        end else begin
            if (cfg_req.valid) r_thresh <= cfg_req.data;
            if (in_req.ready) r_valid <= in_req.valid;
        end
        if (in_req.valid && in_req.ready) r_work <= n_work;
    end

    assign o_work = r_work;
    assign o_valid = r_valid;
endmodule
`default_nettype wire

// ===== hw/rtl/cpt_queue.sv =====
// Short FIFO that decouples the front end from the transform pipeline.
`timescale 1ns / 1ps
`default_nettype none
module cpt_queue #(
    parameter int unsigned DEPTH = cpt_pkg::QueueDepth
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  cpt_pkg::t_work i_work,
    input  wire logic      i_valid,
    output logic           o_ready,
    output cpt_pkg::t_work o_work,
    output logic           o_valid,
    input  wire logic      i_ready
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    cpt_pkg::t_work r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic push, pop;

    assign o_ready = (r_cnt != (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign push = i_valid && o_ready;
    assign pop = o_valid && i_ready;
    assign o_work = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            if (pop) r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(pop);
        end
        if (push) r_mem[r_wp] <= i_work;
    end
endmodule
`default_nettype wire

// ===== hw/rtl/cpt_back.sv =====
// Back end: Clarke, CORDIC sin/cos, Park and magnitude pipeline.
`timescale 1ns / 1ps
`default_nettype none
`include "clarke_park_current_transform_macros.svh"
module cpt_back #(
    parameter int unsigned ANGLE_TABLE_BITS = cpt_pkg::AngleTableBitsDefault
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  cpt_pkg::t_work i_work,
    input  wire logic      i_valid,
    output logic           o_ready,
    cpt_stream_if.source   out_res
);
    localparam int unsigned NS = cpt_pkg::CordicSteps;
    localparam int unsigned SH = 16 - ANGLE_TABLE_BITS;
    localparam int unsigned NSTG = NS + 5;

    // Stage valids; the whole pipe advances when the output can take data.
    logic [NSTG-1:0] r_v;
    logic adv;
    assign adv = !out_res.valid || out_res.ready;
    assign o_ready = adv;

    // Stage 0: Clarke products and angle fold.
    logic signed [50:0] r_pa, r_pb;
    logic signed [33:0] r_x [NS+1];
    logic signed [33:0] r_y [NS+1];
    logic signed [33:0] r_z [NS+1];
    logic [1:0]         r_qd [NS+1];
    logic signed [17:0] r_al [NS+2];
    logic signed [17:0] r_be [NS+2];

    logic [31:0] z32, ru;
    logic [1:0]  quad;
    always_comb begin
        z32 = {(i_work.angle >> SH) << SH, 16'h0};
        quad = 2'((z32 + 32'h2000_0000) >> 30);
        ru = z32 - {quad, 30'h0};
    end

    // Stage 1: rounding of Clarke results.
    function automatic logic signed [17:0] rnd30(input logic signed [50:0] v);
        logic [50:0] m;
        logic [50:0] r;
        begin
            m = v[50] ? 51'(-v) : 51'(v);
            r = (m + (51'd1 << 29)) >> 30;
            rnd30 = v[50] ? 18'(-r) : 18'(r);
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v <= '0;
        else if (adv) r_v <= {r_v[NSTG-2:0], i_valid};
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_pa <= 51'(i_work.a3) * 51'(cpt_pkg::Inv3Q30);
            r_pb <= 51'(21'(i_work.a3) + 21'(2 * 21'(i_work.b3))) * 51'(cpt_pkg::Inv3Sq3Q30);
            r_x[0] <= cpt_pkg::CordicGain;
            r_y[0] <= '0;
            r_z[0] <= 34'(signed'(ru));
            r_qd[0] <= quad;
            r_al[0] <= rnd30(r_pa);
            r_be[0] <= rnd30(r_pb);
        end
    end

    // CORDIC rotations, one per stage; Clarke results ride alongside.
    for (genvar g = 0; g < NS; g++) begin : g_cordic
        always_ff @(posedge i_clk) begin
            if (adv) begin
                if (!r_z[g][33]) begin
                    r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] - cpt_pkg::atan_step(g);
                end else begin
                    r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] + cpt_pkg::atan_step(g);
                end
                r_qd[g+1] <= r_qd[g];
                r_al[g+1] <= r_al[g];
                r_be[g+1] <= r_be[g];
            end
        end
    end

    // Quadrant unfold and rounding to Q1.15.
    function automatic logic signed [17:0] rnd15(input logic signed [33:0] v);
        logic [33:0] m, r;
        begin
            m = v[33] ? 34'(-v) : 34'(v);
            r = (m + 34'd16384) >> 15;
            rnd15 = v[33] ? 18'(-r) : 18'(r);
        end
    endfunction

    logic signed [33:0] cu, su;
    always_comb begin
        case (r_qd[NS])
            2'd0: begin cu = r_x[NS]; su = r_y[NS]; end
            2'd1: begin cu = -r_y[NS]; su = r_x[NS]; end
            2'd2: begin cu = -r_x[NS]; su = -r_y[NS]; end
            default: begin cu = r_y[NS]; su = -r_x[NS]; end
        endcase
    end

    // The Clarke results trail the rotation by one stage, so sin and cos wait one more.
    logic signed [17:0] r_cs, r_sn;
    logic signed [17:0] r_cs_d, r_sn_d;
    logic signed [35:0] r_acs, r_bsn, r_bcs, r_asn, r_aa, r_bb;
    logic signed [17:0] r_al2, r_be2;
    logic signed [36:0] r_ds, r_qs;
    logic [36:0]        r_mag_in;
    logic signed [17:0] r_al3, r_be3;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_cs <= rnd15(cu);
            r_sn <= rnd15(su);
            r_cs_d <= r_cs;
            r_sn_d <= r_sn;
            r_al[NS+1] <= r_al[NS];
            r_be[NS+1] <= r_be[NS];
            r_acs <= r_al[NS+1] * r_cs_d;
            r_bsn <= r_be[NS+1] * r_sn_d;
            r_bcs <= r_be[NS+1] * r_cs_d;
            r_asn <= r_al[NS+1] * r_sn_d;
            r_aa <= r_al[NS+1] * r_al[NS+1];
            r_bb <= r_be[NS+1] * r_be[NS+1];
            r_al2 <= r_al[NS+1];
            r_be2 <= r_be[NS+1];
            r_ds <= 37'(r_acs) + 37'(r_bsn);
            r_qs <= 37'(r_bcs) - 37'(r_asn);
            r_mag_in <= 37'(r_aa) + 37'(r_bb);
            r_al3 <= r_al2;
            r_be3 <= r_be2;
        end
    end

    // Restoring square root: 19 result bits, one per stage.
    localparam int unsigned RB = 19;
    logic [37:0] r_rem [RB+1];
    logic [18:0] r_root [RB+1];
    logic signed [36:0] r_dsp [RB+1];
    logic signed [36:0] r_qsp [RB+1];
    logic signed [17:0] r_alp [RB+1];
    logic signed [17:0] r_bep [RB+1];
    logic [RB:0] r_sv;

    always_comb begin
        r_rem[0] = 38'(r_mag_in);
        r_root[0] = '0;
        r_dsp[0] = r_ds;
        r_qsp[0] = r_qs;
        r_alp[0] = r_al3;
        r_bep[0] = r_be3;
        r_sv[0] = r_v[NS+4];
    end

    for (genvar k = 0; k < RB; k++) begin : g_sqrt
        localparam int unsigned BP = RB - 1 - k;
        logic [37:0] trial;
        assign trial = ({19'd0, r_root[k]} << (BP + 1)) + (38'd1 << (2 * BP));
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_sv[k+1] <= 1'b0;
            else if (adv) r_sv[k+1] <= r_sv[k];
            if (adv) begin
                if (r_rem[k] >= trial) begin
                    r_rem[k+1] <= r_rem[k] - trial;
                    r_root[k+1] <= r_root[k] | (19'd1 << BP);
                end else begin
                    r_rem[k+1] <= r_rem[k];
                    r_root[k+1] <= r_root[k];
                end
                r_dsp[k+1] <= r_dsp[k];
                r_qsp[k+1] <= r_qsp[k];
                r_alp[k+1] <= r_alp[k];
                r_bep[k+1] <= r_bep[k];
            end
        end
    end

    function automatic logic signed [35:0] rnd15w(input logic signed [36:0] v);
        logic [36:0] m, r;
        begin
            m = v[36] ? 37'(-v) : 37'(v);
            r = (m + 37'd16384) >> 15;
            rnd15w = v[36] ? 36'(-r) : 36'(r);
        end
    endfunction

    logic [18:0] mag;
    logic signed [35:0] dcv;
    cpt_pkg::t_out_item res;
    always_comb begin
        mag = (r_root[RB] > 19'd65536) ? 19'd65536 : r_root[RB];
        dcv = (!r_qsp[RB][36] && (r_qsp[RB] != '0)) ? 36'(mag) : -36'(mag);
        res.i_alpha = cpt_pkg::sat16(36'(r_alp[RB]));
        res.i_beta = cpt_pkg::sat16(36'(r_bep[RB]));
        res.i_d = cpt_pkg::sat16(rnd15w(r_dsp[RB]));
        res.i_q = cpt_pkg::sat16(rnd15w(r_qsp[RB]));
        res.dc_current = cpt_pkg::sat16(dcv);
    end

    logic r_ov;
    cpt_pkg::t_out_item r_res;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (adv) r_ov <= r_sv[RB];
        if (adv) r_res <= res;
    end
    assign out_res.valid = r_ov;
    assign out_res.data = r_res;

    `CPT_ASSERT_NEXT(a_hold, i_clk, i_rst_n, out_res.valid && !out_res.ready, out_res.valid, "result dropped under stall")
    `CPT_ASSERT_IMPL(a_ready, i_clk, i_rst_n, !out_res.valid, o_ready, "pipe stalled with empty output")
    `CPT_ASSERT_NEXT(a_flow, i_clk, i_rst_n, adv && r_sv[RB], out_res.valid, "pipeline item lost at output")
endmodule
`default_nettype wire

// ===== hw/rtl/clarke_park_current_transform.sv =====
// Top level of the Clarke/Park current transform with DC current estimate.
`timescale 1ns / 1ps
`default_nettype none
// A request carries three phase currents, three duties, the sector and the angle;
// each produces one result with alpha, beta, d, q and a signed DC current. The block
// accepts one request per clock unless a stalled output has filled the queue. It
// holds no state beyond the duty threshold, which the user must write over the
// configuration channel only while the block is idle; the block does not enforce
// this. A result passes through 45 register stages: the front register, the queue,
// 19 stages for the angle setup and the 18 CORDIC rotations (the Clarke products and
// their rounding run alongside), 4 stages for sin/cos rounding and the Park products
// and sums, 19 square-root stages and the output register. The pipeline length is
// set by the CORDIC and the bit-per-stage square root. A stalled output stops the
// back pipeline while the queue lets the front keep taking requests until it fills.
module clarke_park_current_transform #(
    parameter int unsigned ANGLE_TABLE_BITS = cpt_pkg::AngleTableBitsDefault
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    cpt_stream_if.sink   in_req,
    cpt_stream_if.sink   cfg_req,
    cpt_stream_if.source out_res
);
    cpt_pkg::t_work f_work, q_work;
    logic f_valid, f_ready, q_valid, q_ready;

    cpt_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_req(in_req), .cfg_req(cfg_req),
        .o_work(f_work), .o_valid(f_valid), .i_ready(f_ready)
    );

    cpt_queue #(.DEPTH(cpt_pkg::QueueDepth)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_work(f_work), .i_valid(f_valid),
        .o_ready(f_ready), .o_work(q_work), .o_valid(q_valid), .i_ready(q_ready)
    );

    cpt_back #(.ANGLE_TABLE_BITS(ANGLE_TABLE_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_work(q_work), .i_valid(q_valid),
        .o_ready(q_ready), .out_res(out_res)
    );
endmodule
`default_nettype wire

// ===== tb/tb_clarke_park_current_transform.sv =====
// Testbench for the Clarke/Park current transform with a bit-exact scoreboard.
`timescale 1ns / 1ps
`default_nettype none

// Scoreboard: predicts one result per accepted request and checks results in order.
class cpt_scoreboard;
    cpt_pkg::t_out_item pending_results[$];
    logic [12:0]        duty_threshold;
    int                 error_count;
    int                 angle_bits;

    function new(int bits);
        duty_threshold = cpt_pkg::ThreshReset;
        error_count    = 0;
        angle_bits     = bits;
    endfunction

    // Round to nearest with ties away from zero, then shift right.
    function longint round_shift(longint v, int s);
        longint mag;
        longint r;
        mag = (v < 0) ? -v : v;
        r = (mag + (64'sd1 <<< (s - 1))) >>> s;
        return (v < 0) ? -r : r;
    endfunction

    function longint clip16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // Integer square root by the bit-pair method.
    function longint int_root(longint v);
        longint res;
        longint bitv;
        res = 0;
        bitv = 64'sd1 <<< 62;
        while (bitv > v) bitv = bitv >>> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >>> 1) + bitv;
            end else begin
                res = res >>> 1;
            end
            bitv = bitv >>> 2;
        end
        return res;
    endfunction

    // Rotation-based sine and cosine in Q1.15 for the truncated angle.
    function void angle_to_sin_cos(logic [15:0] angle, output longint sn,
                                   output longint cs);
        int          sh;
        logic [31:0] z32;
        logic [31:0] quad;
        logic [31:0] ru;
        longint      z;
        longint      x;
        longint      y;
        longint      dx;
        longint      dy;
        longint      c;
        longint      s;
        sh   = 16 - angle_bits;
        z32  = {((angle >> sh) << sh), 16'h0};
        quad = (z32 + 32'h2000_0000) >> 30;
        ru   = z32 - (quad << 30);
        z    = ru[31] ? longint'(ru) - 64'sd4294967296 : longint'(ru);
        x    = cpt_pkg::CordicGain;
        y    = 0;
        for (int i = 0; i < cpt_pkg::CordicSteps; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(cpt_pkg::atan_step(i));
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(cpt_pkg::atan_step(i));
            end
        end
        case (quad[1:0])
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
        cs = round_shift(c, 15);
        sn = round_shift(s, 15);
    endfunction

    // Computes the expected result of an accepted request and queues it.
    function void note_request(cpt_pkg::t_in_item req);
        longint a, b, c, pa, pb, a3, b3, alpha, beta, sn, cs, dsum, qsum, mag;
        bit     rebuild;
        cpt_pkg::t_out_item res;
        a = req.phase_a_current;
        b = req.phase_b_current;
        c = req.phase_c_current;
        rebuild = req.duty_a > duty_threshold || req.duty_b > duty_threshold
               || req.duty_c > duty_threshold;
        if (rebuild) begin
            pa = a;
            pb = b;
            case (req.sector)
                3'd1, 3'd6: pa = -b - c;
                3'd2, 3'd3: pb = -a - c;
                default: ;
            endcase
            a3 = 3 * pa;
            b3 = 3 * pb;
        end else begin
            a3 = 2 * a - b - c;
            b3 = 2 * b - a - c;
        end
        alpha = round_shift(a3 * longint'(cpt_pkg::Inv3Q30), 30);
        beta  = round_shift((a3 + 2 * b3) * longint'(cpt_pkg::Inv3Sq3Q30), 30);
        angle_to_sin_cos(req.electrical_angle, sn, cs);
        dsum = alpha * cs + beta * sn;
        qsum = beta * cs - alpha * sn;
        mag  = int_root(alpha * alpha + beta * beta);
        if (mag > 65536) mag = 65536;
        res.i_alpha    = 16'(clip16(alpha));
        res.i_beta     = 16'(clip16(beta));
        res.i_d        = 16'(clip16(round_shift(dsum, 15)));
        res.i_q        = 16'(clip16(round_shift(qsum, 15)));
        res.dc_current = 16'(clip16((qsum > 0) ? mag : -mag));
        pending_results.push_back(res);
    endfunction

    function void report(string field, logic [15:0] exp_v, logic [15:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field,
                     $signed(exp_v), $signed(act_v));
            error_count++;
        end
    endfunction

    function void check_result(cpt_pkg::t_out_item act);
        cpt_pkg::t_out_item exp_r;
        if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, act);
            error_count++;
            return;
        end
        exp_r = pending_results.pop_front();
        report("i_alpha", exp_r.i_alpha, act.i_alpha);
        report("i_beta", exp_r.i_beta, act.i_beta);
        report("i_d", exp_r.i_d, act.i_d);
        report("i_q", exp_r.i_q, act.i_q);
        report("dc_current", exp_r.dc_current, act.dc_current);
    endfunction
endclass

module tb_clarke_park_current_transform;
    localparam int ClockPeriod = 12;
    localparam int CycleLimit  = 400000;
    localparam int DrainCycles = 80;

    logic i_clk;
    logic i_rst_n;
    logic sink_stall_en;
    longint cycle_count;

    cpt_stream_if #(.W($bits(cpt_pkg::t_in_item)))  in_req();
    cpt_stream_if #(.W(13))                         cfg_req();
    cpt_stream_if #(.W($bits(cpt_pkg::t_out_item))) out_res();

    cpt_scoreboard current_board;

    clarke_park_current_transform u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .in_req (in_req.sink),
        .cfg_req(cfg_req.sink),
        .out_res(out_res.source)
    );

    initial begin
        i_clk = 1'b0;
        forever #(ClockPeriod / 2) i_clk = ~i_clk;
    end

    // Accepted requests and results are both seen at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_req.valid && in_req.ready) current_board.note_request(in_req.data);
            if (out_res.valid && out_res.ready) current_board.check_result(out_res.data);
            if (cfg_req.valid && cfg_req.ready) current_board.duty_threshold = cfg_req.data;
        end
    end

    // The result side drops ready at random before each result, unless stalls are off.
    initial begin
        int gap;
        out_res.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            gap = sink_stall_en ? $urandom_range(0, 7) : 0;
            if (gap != 0) begin
                out_res.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            out_res.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_res.valid) @(posedge i_clk);
        end
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CycleLimit) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Sends one request after a random gap; valid stays high across back-to-back requests.
    task automatic send_request(cpt_pkg::t_in_item req, bit allow_gap);
        int gap;
        gap = allow_gap ? $urandom_range(0, 7) : 0;
        if (gap != 0) begin
            in_req.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_req.valid <= 1'b1;
        in_req.data  <= req;
        @(posedge i_clk);
        while (!in_req.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic finish_sending();
        in_req.valid <= 1'b0;
    endtask

    // Waits until every expected result is in, then lets the pipeline settle.
    task automatic wait_drained();
        while (current_board.pending_results.size() != 0) @(negedge i_clk);
        repeat (DrainCycles) @(negedge i_clk);
    endtask

    task automatic write_threshold(logic [12:0] value);
        wait_drained();
        cfg_req.valid <= 1'b1;
        cfg_req.data  <= value;
        @(posedge i_clk);
        while (!cfg_req.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_req.valid <= 1'b0;
    endtask

    function automatic cpt_pkg::t_in_item random_request(logic [12:0] thr);
        cpt_pkg::t_in_item r;
        r.phase_a_current = 16'($urandom);
        r.phase_b_current = 16'($urandom);
        r.phase_c_current = 16'($urandom);
        // Mostly small currents, some near full scale to reach saturation.
        if ($urandom_range(0, 3) != 0) begin
            r.phase_a_current = 16'($signed(r.phase_a_current) >>> $urandom_range(0, 8));
            r.phase_b_current = 16'($signed(r.phase_b_current) >>> $urandom_range(0, 8));
            r.phase_c_current = 16'($signed(r.phase_c_current) >>> $urandom_range(0, 8));
        end
        r.duty_a = 13'($urandom_range(0, 8191));
        r.duty_b = 13'($urandom_range(0, 8191));
        r.duty_c = 13'($urandom_range(0, 8191));
        // Keep duties near the threshold half of the time so both paths occur.
        if ($urandom_range(0, 1) != 0) begin
            r.duty_a = 13'($urandom_range(0, 4096));
            r.duty_b = 13'($urandom_range(0, 4096));
            r.duty_c = (thr == 13'h1fff) ? thr : thr + 13'($urandom_range(0, 1));
        end
        r.sector           = 3'($urandom_range(0, 7));
        r.electrical_angle = 16'($urandom);
        return r;
    endfunction

    task automatic directed_phase();
        cpt_pkg::t_in_item r;
        logic signed [15:0] extremes[4] = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff};
        for (int k = 0; k < 8; k++) begin
            // Rebuild path, every sector value including zero and seven.
            r = '0;
            r.phase_a_current  = extremes[k % 4];
            r.phase_b_current  = extremes[(k + 1) % 4];
            r.phase_c_current  = extremes[(k + 2) % 4];
            r.duty_a           = 13'h1fff;
            r.sector           = 3'(k);
            r.electrical_angle = 16'(k * 16'h2000);
            send_request(r, 1'b0);
        end
        for (int k = 0; k < 8; k++) begin
            // Mean-removal path at angles just below a half and a full turn.
            r = '0;
            r.phase_a_current  = extremes[(k + 1) % 4];
            r.phase_b_current  = extremes[k % 4];
            r.phase_c_current  = extremes[(k + 3) % 4];
            r.duty_b           = 13'd3686;
            r.sector           = 3'(k);
            r.electrical_angle = (k % 2 != 0) ? 16'hffff : 16'(k * 16'h4000 - 1);
            send_request(r, 1'b1);
        end
        // A zero vector gives a zero q and thus the negative sign branch.
        r = '0;
        r.electrical_angle = 16'h003f;
        send_request(r, 1'b0);
        finish_sending();
    endtask

    task automatic random_phase(int count, logic [12:0] thr);
        for (int n = 0; n < count; n++) begin
            sink_stall_en = ((n / 64) % 4) != 3;
            send_request(random_request(thr), ((n / 64) % 4) != 2);
        end
        finish_sending();
    endtask

    initial begin
        logic [12:0] thresholds[6] = '{13'd0, 13'h1fff, 13'd4096, 13'd2048, 13'd3686,
                                      13'd1000};
        current_board = new(cpt_pkg::AngleTableBitsDefault);
        sink_stall_en = 1'b1;
        i_rst_n       = 1'b0;
        in_req.valid  = 1'b0;
        in_req.data   = '0;
        cfg_req.valid = 1'b0;
        cfg_req.data  = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset threshold first, then each register setting with its own batch.
        directed_phase();
        random_phase(300, cpt_pkg::ThreshReset);
        foreach (thresholds[t]) begin
            write_threshold(thresholds[t]);
            random_phase(220, thresholds[t]);
        end
        write_threshold(13'($urandom_range(0, 8191)));
        random_phase(80, current_board.duty_threshold);
        wait_drained();

        if (current_board.error_count == 0 && current_board.pending_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/cpt_pkg.sv
hw/rtl/cpt_stream_if.sv
hw/rtl/cpt_front.sv
hw/rtl/cpt_queue.sv
hw/rtl/cpt_back.sv
hw/rtl/clarke_park_current_transform.sv
tb/tb_clarke_park_current_transform.sv
